// File: hw/rtl/ptf_pkg.sv
package ptf_pkg;

    localparam int DIGITS_MAX = 11;
    localparam int DIGIT_IDX_W = $clog2(DIGITS_MAX);
    localparam int NULL_LEN = 6;
    localparam int NULL_IDX_W = $clog2(NULL_LEN);

    // divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for any 32-bit v
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SHIFT = 35;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_I  = 8'h69;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_S  = 8'h73;

    typedef enum logic [1:0] {
        CMD_FMT = 2'd0,
        CMD_ARG = 2'd1,
        CMD_STR = 2'd2,
        CMD_END = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        RS_CHAR   = 2'd0,
        RS_REPORT = 2'd1,
        RS_ERROR  = 2'd2
    } t_res_status;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_PCT  = 2'd1,
        PH_ARG  = 2'd2,
        PH_STR  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        K_SDEC = 3'd0,
        K_UDEC = 3'd1,
        K_LHEX = 3'd2,
        K_UHEX = 3'd3,
        K_CHAR = 3'd4,
        K_STR  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        CS_NONE,
        CS_BYTE,
        CS_SAVED,
        CS_PCT,
        CS_MINUS,
        CS_ARG,
        CS_NULL,
        CS_DIGIT
    } t_char_sel;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SPEC,
        FS_NULL,
        FS_DIV,
        FS_DIGITS
    } t_fsm;

    typedef struct packed {
        logic        emit;
        t_char_sel   sel;
        t_res_status rstat;
        logic        last;
        logic        phase_we;
        t_phase      phase_d;
        logic        kind_we;
        t_kind       kind_d;
        logic        byte_we;
        logic        value_load;
        logic        div_step;
        logic        digit_pop;
        logic        null_clear;
        logic        null_step;
        logic        str_load;
        logic        str_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic   out_free;
        t_phase phase;
        t_kind  kind;
        logic   arg_neg;
        logic   arg_zero;
        logic   div_done;
        logic   dcnt_one;
        logic   null_last;
        logic   str_one;
    } t_dp_stat;

    function automatic logic [7:0] null_char(input logic [NULL_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6C;
            3'd4:    c = 8'h6C;
            3'd5:    c = 8'h29;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else if (upper) begin
            c = 8'h41 + {4'd0, d} - 8'd10;
        end else begin
            c = 8'h61 + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/ptf_ctrl.sv
module ptf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_text_byte,
    input  logic              i_arg_is_null,
    input  ptf_pkg::t_dp_stat i_stat,
    output ptf_pkg::t_dp_cmd  o_cmd
);
    import ptf_pkg::*;

    t_fsm     r_state;
    t_fsm     n_state;
    t_dp_cmd  cmd;
    logic     accept;
    t_command command;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign command    = t_command'(i_command);
    assign o_in_stall = !((r_state == FS_IDLE) && i_stat.out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = cmd;

    always_comb begin
        n_state = r_state;
        cmd = '0;
        cmd.sel = CS_NONE;
        cmd.rstat = RS_CHAR;
        cmd.phase_d = PH_TEXT;
        cmd.kind_d = K_SDEC;
        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    case (command)
                        CMD_END: begin
                            cmd.emit = 1'b1;
                            cmd.rstat = RS_REPORT;
                            cmd.last = 1'b1;
                            cmd.phase_we = 1'b1;
                            cmd.kind_we = 1'b1;
                        end
                        CMD_FMT: begin
                            case (i_stat.phase)
                                PH_TEXT: begin
                                    if (i_text_byte == CH_PCT) begin
                                        cmd.phase_we = 1'b1;
                                        cmd.phase_d = PH_PCT;
                                    end else begin
                                        cmd.emit = 1'b1;
                                        cmd.sel = CS_BYTE;
                                        cmd.last = 1'b1;
                                    end
                                end
                                PH_PCT: begin
                                    cmd.phase_we = 1'b1;
                                    cmd.phase_d = PH_ARG;
                                    cmd.kind_we = 1'b1;
                                    case (i_text_byte)
                                        CH_LO_D, CH_LO_I: cmd.kind_d = K_SDEC;
                                        CH_LO_U: cmd.kind_d = K_UDEC;
                                        CH_LO_X: cmd.kind_d = K_LHEX;
                                        CH_UP_X: cmd.kind_d = K_UHEX;
                                        CH_LO_C: cmd.kind_d = K_CHAR;
                                        CH_LO_S: cmd.kind_d = K_STR;
                                        CH_PCT: begin
                                            cmd.kind_we = 1'b0;
                                            cmd.phase_d = PH_TEXT;
                                            cmd.emit = 1'b1;
                                            cmd.sel = CS_PCT;
                                            cmd.last = 1'b1;
                                        end
                                        default: begin
                                            // unknown specifier: '%' now, the byte next
                                            cmd.kind_we = 1'b0;
                                            cmd.phase_d = PH_TEXT;
                                            cmd.emit = 1'b1;
                                            cmd.sel = CS_PCT;
                                            cmd.byte_we = 1'b1;
                                            n_state = FS_SPEC;
                                        end
                                    endcase
                                end
                                default: begin
                                    cmd.emit = 1'b1;
                                    cmd.rstat = RS_ERROR;
                                    cmd.last = 1'b1;
                                end
                            endcase
                        end
                        CMD_ARG: begin
                            if (i_stat.phase == PH_ARG) begin
                                cmd.phase_we = 1'b1;
                                case (i_stat.kind)
                                    K_UDEC, K_LHEX, K_UHEX: begin
                                        cmd.value_load = 1'b1;
                                        n_state = FS_DIV;
                                    end
                                    K_CHAR: begin
                                        cmd.emit = 1'b1;
                                        cmd.sel = CS_ARG;
                                        cmd.last = 1'b1;
                                    end
                                    K_STR: begin
                                        if (i_arg_is_null) begin
                                            cmd.null_clear = 1'b1;
                                            n_state = FS_NULL;
                                        end else if (!i_stat.arg_zero) begin
                                            cmd.str_load = 1'b1;
                                            cmd.phase_d = PH_STR;
                                        end
                                    end
                                    default: begin
                                        // signed decimal: sign goes out first
                                        cmd.value_load = 1'b1;
                                        if (i_stat.arg_neg) begin
                                            cmd.emit = 1'b1;
                                            cmd.sel = CS_MINUS;
                                        end
                                        n_state = FS_DIV;
                                    end
                                endcase
                            end else begin
                                cmd.emit = 1'b1;
                                cmd.rstat = RS_ERROR;
                                cmd.last = 1'b1;
                            end
                        end
                        CMD_STR: begin
                            if (i_stat.phase == PH_STR) begin
                                cmd.emit = 1'b1;
                                cmd.sel = CS_BYTE;
                                cmd.last = 1'b1;
                                cmd.str_dec = 1'b1;
                                if (i_stat.str_one) begin
                                    cmd.phase_we = 1'b1;
                                end
                            end else begin
                                cmd.emit = 1'b1;
                                cmd.rstat = RS_ERROR;
                                cmd.last = 1'b1;
                            end
                        end
                        default: begin
                            cmd.emit = 1'b1;
                            cmd.rstat = RS_ERROR;
                            cmd.last = 1'b1;
                        end
                    endcase
                end
            end
            FS_SPEC: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel = CS_SAVED;
                    cmd.last = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            FS_NULL: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel = CS_NULL;
                    cmd.last = i_stat.null_last;
                    cmd.null_step = 1'b1;
                    if (i_stat.null_last) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            FS_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = FS_DIGITS;
                end
            end
            FS_DIGITS: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel = CS_DIGIT;
                    cmd.last = i_stat.dcnt_one;
                    cmd.digit_pop = 1'b1;
                    if (i_stat.dcnt_one) begin
                        n_state = FS_IDLE;
                    end
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ptf_datapath.sv
module ptf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_text_byte,
    input  logic [31:0]       i_arg_value,
    input  ptf_pkg::t_dp_cmd  i_cmd,
    output ptf_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_char,
    output logic [1:0]        o_status,
    output logic [31:0]       o_chars_written,
    output logic              o_last
);
    import ptf_pkg::*;

    t_phase                r_phase;
    t_kind                 r_kind;
    logic [31:0]           r_str_left;
    logic [31:0]           r_total;
    logic [7:0]            r_byte;
    logic [31:0]           r_value;
    logic [DIGIT_IDX_W-1:0] r_dcnt;
    logic [NULL_IDX_W-1:0] r_null_idx;
    logic [3:0]            r_digit_buf [DIGITS_MAX];

    logic                  r_out_valid;
    logic [7:0]            r_out_char;
    t_res_status           r_out_status;
    logic [31:0]           r_out_count;
    logic                  r_out_last;

    logic                  is_hex;
    logic                  upper;
    logic [63:0]           prod;
    logic [31:0]           quot;
    logic [31:0]           rem10;
    logic [3:0]            digit;
    logic [31:0]           next_value;
    logic [DIGIT_IDX_W-1:0] rd_idx;
    logic [31:0]           total_inc;
    logic [7:0]            emit_char;

    assign is_hex = (r_kind == K_LHEX) || (r_kind == K_UHEX);
    assign upper  = (r_kind == K_UHEX);

    // one digit per cycle, least significant first
    assign prod       = r_value * RECIP10;
    assign quot       = {{(RECIP10_SHIFT-32){1'b0}}, prod[63:RECIP10_SHIFT]};
    assign rem10      = r_value - (quot << 3) - (quot << 1);
    assign digit      = is_hex ? r_value[3:0] : rem10[3:0];
    assign next_value = is_hex ? {4'd0, r_value[31:4]} : quot;
    assign rd_idx     = r_dcnt - 1'b1;

    assign total_inc = (r_total == '1) ? r_total : r_total + 32'd1;

    always_comb begin
        case (i_cmd.sel)
            CS_BYTE:  emit_char = i_text_byte;
            CS_SAVED: emit_char = r_byte;
            CS_PCT:   emit_char = CH_PCT;
            CS_MINUS: emit_char = CH_MINUS;
            CS_ARG:   emit_char = i_arg_value[7:0];
            CS_NULL:  emit_char = null_char(r_null_idx);
            CS_DIGIT: emit_char = digit_char(r_digit_buf[rd_idx], upper);
            default:  emit_char = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TEXT;
            r_kind      <= K_SDEC;
            r_str_left  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_null_idx  <= '0;
        end else begin
            if (i_cmd.phase_we) begin
                r_phase <= i_cmd.phase_d;
            end
            if (i_cmd.kind_we) begin
                r_kind <= i_cmd.kind_d;
            end
            if (i_cmd.str_load) begin
                r_str_left <= i_arg_value;
            end else if (i_cmd.str_dec) begin
                r_str_left <= r_str_left - 32'd1;
            end
            if (i_cmd.value_load) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 1'b1;
            end else if (i_cmd.digit_pop) begin
                r_dcnt <= rd_idx;
            end
            if (i_cmd.null_clear) begin
                r_null_idx <= '0;
            end else if (i_cmd.null_step) begin
                r_null_idx <= r_null_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                case (i_cmd.rstat)
                    RS_CHAR:   r_total <= total_inc;
                    RS_REPORT: r_total <= '0;
                    default:   r_total <= r_total;
                endcase
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_we) begin
            r_byte <= i_text_byte;
        end
        if (i_cmd.value_load) begin
            if ((r_kind == K_SDEC) && i_arg_value[31]) begin
                r_value <= 32'd0 - i_arg_value;
            end else begin
                r_value <= i_arg_value;
            end
        end else if (i_cmd.div_step) begin
            r_value <= next_value;
            r_digit_buf[r_dcnt] <= digit;
        end
        if (i_cmd.emit) begin
            r_out_char   <= emit_char;
            r_out_status <= i_cmd.rstat;
            r_out_last   <= i_cmd.last;
            r_out_count  <= (i_cmd.rstat == RS_CHAR) ? total_inc : r_total;
        end
    end

    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.phase     = r_phase;
    assign o_stat.kind      = r_kind;
    assign o_stat.arg_neg   = i_arg_value[31];
    assign o_stat.arg_zero  = (i_arg_value == 32'd0);
    assign o_stat.div_done  = (next_value == 32'd0);
    assign o_stat.dcnt_one  = (r_dcnt == DIGIT_IDX_W'(1));
    assign o_stat.null_last = (r_null_idx == NULL_IDX_W'(NULL_LEN - 1));
    assign o_stat.str_one   = (r_str_left == 32'd1);

    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_status        = r_out_status;
    assign o_chars_written = r_out_count;
    assign o_last          = r_out_last;

endmodule

// File: hw/rtl/printf_text_formatter_core.sv
// printf-style text formatter. Format characters, argument words, string characters and an
// end-of-format mark arrive one word at a time; each word yields zero to eleven output words
// (a character, an end-of-format count report or a misplaced-item error), the final one
// flagged by o_last, each carrying the saturating running character count. A numeric
// argument goes through a digit loop first: one digit per cycle from a single 32x32
// multiply by the reciprocal of ten (or a 4-bit shift for hex), then one digit out per
// cycle while the output is not stalled. Input is stalled until every output word of the
// current item is in the output register.
module printf_text_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_text_byte,
    input  logic [31:0] i_arg_value,
    input  logic        i_arg_is_null,
    // output words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic [1:0]  o_status,
    output logic [31:0] o_chars_written,
    output logic        o_last
);
    import ptf_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: decodes each word against the current phase and steps multi-word output
    ptf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_text_byte   (i_text_byte),
        .i_arg_is_null (i_arg_is_null),
        .i_stat        (dp_stat),
        .o_cmd         (dp_cmd)
    );

    // phase and count state, digit loop with digit scratch, output register
    ptf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_text_byte     (i_text_byte),
        .i_arg_value     (i_arg_value),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_status        (o_status),
        .o_chars_written (o_chars_written),
        .o_last          (o_last)
    );

endmodule

// File: bench/printf_text_formatter_core_tb.sv
module printf_text_formatter_core_tb;
    import ptf_pkg::*;

    // one expected output word
    typedef struct packed {
        logic [7:0]  ch;
        t_res_status st;
        logic [31:0] cnt;
        logic        last;
    } t_fmt_word;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_command    cmd;
        logic [7:0]  txt;
        logic [31:0] arg;
        logic        nul;
        logic        typed;
        t_fmt_word   want;
    } t_stim_row;

    localparam int        DIR_ROWS   = 28;
    localparam int        RAND_WORDS = 450;
    localparam t_fmt_word NO_WANT    = '0;
    localparam logic [47:0] NULL_TEXT = "(null)";
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_UP_A = 8'h41;

    // clock and synchronous active-low reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    // input channel, all driven from time zero
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    t_command    i_command     = CMD_FMT;
    logic [7:0]  i_text_byte   = 8'h00;
    logic [31:0] i_arg_value   = 32'h0;
    logic        i_arg_is_null = 1'b0;

    // output channel
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_char;
    logic [1:0]  o_status;
    logic [31:0] o_chars_written;
    logic        o_last;

    printf_text_formatter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_text_byte     (i_text_byte),
        .i_arg_value     (i_arg_value),
        .i_arg_is_null   (i_arg_is_null),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_status        (o_status),
        .o_chars_written (o_chars_written),
        .o_last          (o_last)
    );

    // formatter state as the testbench predicts it
    t_phase      fmt_phase     = PH_TEXT;
    t_kind       fmt_kind      = K_SDEC;
    logic [31:0] str_remaining = '0;
    logic [31:0] char_total    = '0;

    t_fmt_word expected_words[$];
    int        mismatches = 0;
    int        words_sent = 0;
    bit        calm       = 1'b0;   // while set neither side idles

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // argument values leaning on the corners of the 32-bit range
    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return $urandom_range(0, 999);
            default: return $urandom();
        endcase
    endfunction

    // random byte and random flag at their port widths
    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // every emitted character bumps the saturating total
    task automatic emit_text(input logic [7:0] c);
        if (char_total != 32'hFFFF_FFFF) char_total++;
        expected_words.push_back('{c, RS_CHAR, char_total, 1'b0});
    endtask

    // decimal or hex digits, most significant first, no leading zeros
    task automatic emit_digits(input logic [31:0] v, input bit hex, input bit upper);
        logic [3:0]  dg [0:DIGITS_MAX-1];
        logic [31:0] rem;
        int          nd;
        nd = 0;
        do begin
            rem = v % 32'd10;
            dg[nd] = hex ? v[3:0] : rem[3:0];
            v = hex ? (v >> 4) : (v / 32'd10);
            nd++;
        end while (v != 0 && nd < DIGITS_MAX);
        while (nd > 0) begin
            nd--;
            if (dg[nd] < 4'd10)
                emit_text(ASCII_ZERO + {4'd0, dg[nd]});
            else
                emit_text((upper ? ASCII_UP_A : ASCII_LO_A) + {4'd0, dg[nd]} - 8'd10);
        end
    endtask

    // advance the predicted formatter by one accepted input word
    task automatic apply_format_word(input t_command cmd, input logic [7:0] b,
                                     input logic [31:0] a, input logic nul,
                                     output int produced);
        int  first;
        bit  misplaced;
        first     = expected_words.size();
        misplaced = 1'b0;
        case (cmd)
            CMD_END: begin
                // report, then clear everything including a pending conversion
                expected_words.push_back('{8'h00, RS_REPORT, char_total, 1'b0});
                char_total    = '0;
                fmt_phase     = PH_TEXT;
                fmt_kind      = K_SDEC;
                str_remaining = '0;
            end
            CMD_FMT: begin
                if (fmt_phase == PH_TEXT) begin
                    if (b == CH_PCT) fmt_phase = PH_PCT;
                    else emit_text(b);
                end else if (fmt_phase == PH_PCT) begin
                    fmt_phase = PH_ARG;
                    case (b)
                        CH_LO_D, CH_LO_I: fmt_kind = K_SDEC;
                        CH_LO_U:          fmt_kind = K_UDEC;
                        CH_LO_X:          fmt_kind = K_LHEX;
                        CH_UP_X:          fmt_kind = K_UHEX;
                        CH_LO_C:          fmt_kind = K_CHAR;
                        CH_LO_S:          fmt_kind = K_STR;
                        CH_PCT: begin
                            fmt_phase = PH_TEXT;
                            emit_text(CH_PCT);
                        end
                        default: begin
                            // unknown specifier echoes both characters
                            fmt_phase = PH_TEXT;
                            emit_text(CH_PCT);
                            emit_text(b);
                        end
                    endcase
                end else begin
                    misplaced = 1'b1;
                end
            end
            CMD_ARG: begin
                if (fmt_phase == PH_ARG) begin
                    fmt_phase = PH_TEXT;
                    case (fmt_kind)
                        K_UDEC: emit_digits(a, 1'b0, 1'b0);
                        K_LHEX: emit_digits(a, 1'b1, 1'b0);
                        K_UHEX: emit_digits(a, 1'b1, 1'b1);
                        K_CHAR: emit_text(a[7:0]);
                        K_STR: begin
                            if (nul) begin
                                for (int i = 0; i < NULL_LEN; i++)
                                    emit_text(NULL_TEXT[47-8*i -: 8]);
                            end else if (a != 0) begin
                                str_remaining = a;
                                fmt_phase     = PH_STR;
                            end
                        end
                        default: begin
                            // negate as unsigned so the minimum integer prints in full
                            if (a[31]) begin
                                emit_text(CH_MINUS);
                                emit_digits(32'd0 - a, 1'b0, 1'b0);
                            end else begin
                                emit_digits(a, 1'b0, 1'b0);
                            end
                        end
                    endcase
                end else begin
                    misplaced = 1'b1;
                end
            end
            default: begin
                if (fmt_phase == PH_STR) begin
                    emit_text(b);
                    str_remaining--;
                    if (str_remaining == 0) fmt_phase = PH_TEXT;
                end else begin
                    misplaced = 1'b1;
                end
            end
        endcase
        if (misplaced)
            expected_words.push_back('{8'h00, RS_ERROR, char_total, 1'b0});
        produced = expected_words.size() - first;
        if (produced > 0)
            expected_words[expected_words.size()-1].last = 1'b1;
    endtask

    // present one word at the falling edge and hold it until accepted
    task automatic drive_word(input t_command cmd, input logic [7:0] b,
                              input logic [31:0] a, input logic nul);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command     <= cmd;
        i_text_byte   <= b;
        i_arg_value   <= a;
        i_arg_is_null <= nul;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // random part: send, predict and count
    task automatic push_word(input t_command cmd, input logic [7:0] b,
                             input logic [31:0] a, input logic nul);
        int produced;
        drive_word(cmd, b, a, nul);
        apply_format_word(cmd, b, a, nul, produced);
        words_sent++;
    endtask

    // output side stalls in runs, with the stall released between runs
    initial begin : out_stall_gen
        int stall_run;
        stall_run = 0;
        forever begin
            @(negedge i_clk);
            if (stall_run > 0) begin
                i_out_stall <= 1'b1;
                stall_run--;
            end else begin
                i_out_stall <= 1'b0;
                stall_run = idle_len();
            end
        end
    end

    // compare each accepted output word with the oldest expectation
    always @(posedge i_clk) begin : out_check
        t_fmt_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, char", 32'(o_out_char), 32'h0);
            end else begin
                want = expected_words.pop_front();
                if (o_out_char !== want.ch)
                    report_mismatch("char", 32'(o_out_char), 32'(want.ch));
                if (o_status !== want.st)
                    report_mismatch("status", 32'(o_status), 32'(want.st));
                if (o_chars_written !== want.cnt)
                    report_mismatch("chars_written", o_chars_written, want.cnt);
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : main
        t_stim_row   dir_rows [0:DIR_ROWS-1];
        t_stim_row   row;
        int          produced;
        int          r;
        int          len;
        logic        nul;
        logic [7:0]  spec;
        bit          cut;

        // directed words: misplaced items from reset, zero and top bytes, percent
        // handling, minimum integer, zero value, null and empty strings, early end
        // and a trailing percent
        dir_rows = '{
            '{CMD_END, 8'h00,   32'h0,         1'b0, 1'b1, '{8'h00, RS_REPORT, 32'd0, 1'b1}},
            '{CMD_ARG, 8'h00,   32'hFFFF_FFFF, 1'b1, 1'b1, '{8'h00, RS_ERROR,  32'd0, 1'b1}},
            '{CMD_STR, 8'hFF,   32'h0,         1'b0, 1'b1, '{8'h00, RS_ERROR,  32'd0, 1'b1}},
            '{CMD_FMT, 8'h00,   32'h0,         1'b0, 1'b1, '{8'h00, RS_CHAR,   32'd1, 1'b1}},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b1, '{CH_PCT, RS_CHAR,  32'd2, 1'b1}},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, 8'h71,   32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_LO_D, 32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, 8'hFF,   32'h0,         1'b0, 1'b1, '{8'h00, RS_ERROR,  32'd4, 1'b1}},
            '{CMD_ARG, 8'h00,   32'h8000_0000, 1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_LO_U, 32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_ARG, 8'h00,   32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_LO_S, 32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_ARG, 8'h00,   32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_LO_S, 32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_ARG, 8'h00,   32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_LO_S, 32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_ARG, 8'h00,   32'd3,         1'b0, 1'b0, NO_WANT},
            '{CMD_STR, 8'hFF,   32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_END, 8'h00,   32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_FMT, CH_PCT,  32'h0,         1'b0, 1'b0, NO_WANT},
            '{CMD_END, 8'h00,   32'h0,         1'b0, 1'b1, '{8'h00, RS_REPORT, 32'd0, 1'b1}}
        };

        // reset held low from time zero, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; typed rows replace the predicted word with the typed one
        for (int n = 0; n < DIR_ROWS; n++) begin
            row = dir_rows[n];
            drive_word(row.cmd, row.txt, row.arg, row.nul);
            apply_format_word(row.cmd, row.txt, row.arg, row.nul, produced);
            if (row.typed) begin
                repeat (produced) void'(expected_words.pop_back());
                expected_words.push_back(row.want);
            end
        end

        // random part: mostly well-formed format sequences with random content
        while (words_sent < RAND_WORDS) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            // well-formed sequences start from plain text
            if (r < 83 && fmt_phase != PH_TEXT)
                push_word(CMD_END, rnd_byte(), $urandom(), rnd_bit());
            if (r < 30) begin
                // plain text run
                len = $urandom_range(1, 5);
                repeat (len)
                    push_word(CMD_FMT, rnd_byte(), $urandom(), rnd_bit());
            end else if (r < 75) begin
                // conversion with its argument word
                case ($urandom_range(0, 6))
                    0:       spec = CH_LO_D;
                    1:       spec = CH_LO_I;
                    2:       spec = CH_LO_U;
                    3:       spec = CH_LO_X;
                    4:       spec = CH_UP_X;
                    5:       spec = CH_LO_C;
                    default: spec = CH_LO_S;
                endcase
                push_word(CMD_FMT, CH_PCT, $urandom(), rnd_bit());
                push_word(CMD_FMT, spec, $urandom(), rnd_bit());
                if (spec != CH_LO_S) begin
                    push_word(CMD_ARG, rnd_byte(), pick_arg(), rnd_bit());
                end else begin
                    nul = ($urandom_range(0, 4) == 0);
                    len = nul ? 0 : $urandom_range(0, 6);
                    push_word(CMD_ARG, rnd_byte(),
                              nul ? $urandom() : 32'(len), nul);
                    // string body, now and then cut short or interrupted
                    cut = 1'b0;
                    for (int k = 0; k < len && !cut; k++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            push_word(CMD_END, 8'h00, $urandom(), 1'b0);
                            cut = 1'b1;
                        end else begin
                            if ($urandom_range(0, 24) == 0)
                                push_word(CMD_FMT, rnd_byte(), $urandom(), 1'b0);
                            push_word(CMD_STR, rnd_byte(), $urandom(), rnd_bit());
                        end
                    end
                end
            end else if (r < 83) begin
                // percent followed by any byte, unknown specifiers mostly
                push_word(CMD_FMT, CH_PCT, $urandom(), 1'b0);
                push_word(CMD_FMT, rnd_byte(), $urandom(), rnd_bit());
            end else if (r < 90) begin
                push_word(CMD_END, rnd_byte(), $urandom(), rnd_bit());
            end else begin
                // noise: format, argument or string words in any phase
                len = $urandom_range(1, 3);
                repeat (len)
                    push_word(t_command'($urandom_range(0, 2)), rnd_byte(),
                              pick_arg(), rnd_bit());
            end
        end

        // drain, then give a stray word time to show up
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ptf_pkg.sv
hw/rtl/ptf_ctrl.sv
hw/rtl/ptf_datapath.sv
hw/rtl/printf_text_formatter_core.sv
bench/printf_text_formatter_core_tb.sv
